// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== rtl/core/rgbls_pkg.sv =====
// Shared commands, register indexes and constants of the LED strip serializer.
package rgbls_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_SET   = 2'd1;
  localparam cmd_t CMD_START = 2'd2;
  localparam cmd_t CMD_CLEAR = 2'd3;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ZERO_HIGH = 3'd0;
  localparam reg_idx_t REG_ZERO_LOW  = 3'd1;
  localparam reg_idx_t REG_ONE_HIGH  = 3'd2;
  localparam reg_idx_t REG_ONE_LOW   = 3'd3;
  localparam reg_idx_t REG_LATCH     = 3'd4;
  localparam reg_idx_t REG_ACTIVE    = 3'd5;

  typedef logic [15:0] ticks_t;
  typedef logic [23:0] color_t;

  localparam ticks_t     RST_ZERO_HIGH = 16'd50;
  localparam ticks_t     RST_ZERO_LOW  = 16'd100;
  localparam ticks_t     RST_ONE_HIGH  = 16'd100;
  localparam ticks_t     RST_ONE_LOW   = 16'd50;
  localparam ticks_t     RST_LATCH     = 16'd8000;
  localparam logic [6:0] RST_ACTIVE    = 7'd60;

  localparam logic [4:0] BITS_PER_LED  = 5'd24;

endpackage

// ===== rtl/core/rgb_led_strip_serializer.sv =====
// Top level of the one-wire RGB LED strip serializer with its frame store memory.
//
//  channel | direction | handshake           | beat contents
//  in_     | in        | in_valid / in_stall | cmd, led_index, red, green, blue
//  out_    | out       | out_valid/out_stall | pin_level, busy_res, accepted, frame_done
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle in unless stalled, one registered result beat per input beat.
//  The frame store read is registered ahead of use; the next LED is prefetched.
//  Reset and a clear command start a zeroing pass over all MAX_LEDS entries of the
//  frame store; during it only set commands stall, everything else flows.
//  in_stall follows out_stall while the output register holds a beat.
module rgb_led_strip_serializer #(
  parameter int MAX_LEDS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [5:0]          in_led_index,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_pin_level,
  output logic                out_busy_res,
  output logic                out_accepted,
  output logic                out_frame_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  function automatic rgbls_pkg::ticks_t at_least_one(input rgbls_pkg::ticks_t v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  // configuration registers
  rgbls_pkg::ticks_t zero_high_r, zero_low_r, one_high_r, one_low_r, latch_r;
  logic [6:0]        active_r;

  // refresh state
  logic [1:0]          phase_r, phase_nxt;
  rgbls_pkg::color_t   shift_r, shift_nxt;
  logic [CNT_W-1:0]    led_cnt_r, led_cnt_nxt;
  logic [4:0]          bit_cnt_r, bit_cnt_nxt;
  rgbls_pkg::ticks_t   tick_cnt_r, tick_cnt_nxt;

  // zeroing pass
  logic                clr_active_r, clr_active_nxt;
  logic [AW-1:0]       clr_ptr_r, clr_ptr_nxt;

  // frame store
  rgbls_pkg::color_t   mem [MAX_LEDS];
  rgbls_pkg::color_t   mem_q_r, fwd_data_r, rd_word, mem_wdata;
  logic                fwd_r, rd_zero_r, mem_we;
  logic [AW-1:0]       rd_addr, mem_waddr;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_pin_r, out_busy_r, out_acc_r, out_done_r;
  logic pin, acc, done, clear_start, in_acc;

  logic [CNT_W-1:0]    led_count, led_inc;
  rgbls_pkg::ticks_t   hi_thr, lo_thr, latch_thr;
  logic [16:0]         tick_inc;
  logic [4:0]          bit_inc;
  logic                is_set, bit_one;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= rgbls_pkg::RST_ZERO_HIGH;
      zero_low_r  <= rgbls_pkg::RST_ZERO_LOW;
      one_high_r  <= rgbls_pkg::RST_ONE_HIGH;
      one_low_r   <= rgbls_pkg::RST_ONE_LOW;
      latch_r     <= rgbls_pkg::RST_LATCH;
      active_r    <= rgbls_pkg::RST_ACTIVE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgbls_pkg::REG_ZERO_HIGH: zero_high_r <= cfg_data;
        rgbls_pkg::REG_ZERO_LOW:  zero_low_r  <= cfg_data;
        rgbls_pkg::REG_ONE_HIGH:  one_high_r  <= cfg_data;
        rgbls_pkg::REG_ONE_LOW:   one_low_r   <= cfg_data;
        rgbls_pkg::REG_LATCH:     latch_r     <= cfg_data;
        rgbls_pkg::REG_ACTIVE:    active_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign led_count = (32'(active_r) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : CNT_W'(active_r);

  assign is_set   = (in_cmd == rgbls_pkg::CMD_SET);
  assign in_stall = (out_valid_r && out_stall) || (clr_active_r && is_set);
  assign in_acc   = in_valid && !in_stall;

  // prefetch LED 0 while idle or latching, else the LED after the current one
  assign rd_addr = (phase_r == PH_IDLE || phase_r == PH_LATCH) ? '0 : AW'(led_cnt_r + 1'b1);
  assign rd_word = rd_zero_r ? '0 : (fwd_r ? fwd_data_r : mem_q_r);

  assign bit_one   = shift_r[23];
  assign hi_thr    = at_least_one(bit_one ? one_high_r : zero_high_r);
  assign lo_thr    = at_least_one(bit_one ? one_low_r : zero_low_r);
  assign latch_thr = at_least_one(latch_r);
  assign tick_inc  = {1'b0, tick_cnt_r} + 17'd1;
  assign bit_inc   = bit_cnt_r + 5'd1;
  assign led_inc   = led_cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    led_cnt_nxt  = led_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    tick_cnt_nxt = tick_cnt_r;
    pin          = 1'b0;
    acc          = 1'b0;
    done         = 1'b0;
    clear_start  = 1'b0;
    if (in_acc) begin
      if (in_cmd == rgbls_pkg::CMD_TICK) begin
        acc = 1'b1;
        case (phase_r)
          PH_HIGH: begin
            pin          = 1'b1;
            tick_cnt_nxt = tick_inc[15:0];
            if (tick_inc >= {1'b0, hi_thr}) begin
              tick_cnt_nxt = '0;
              phase_nxt    = PH_LOW;
            end
          end
          PH_LOW: begin
            tick_cnt_nxt = tick_inc[15:0];
            if (tick_inc >= {1'b0, lo_thr}) begin
              tick_cnt_nxt = '0;
              shift_nxt    = {shift_r[22:0], 1'b0};
              bit_cnt_nxt  = bit_inc;
              phase_nxt    = PH_HIGH;
              if (bit_inc >= rgbls_pkg::BITS_PER_LED) begin
                bit_cnt_nxt = '0;
                led_cnt_nxt = led_inc;
                if (led_inc >= led_count) begin
                  shift_nxt = '0;
                  phase_nxt = PH_LATCH;
                end else begin
                  shift_nxt = rd_word;
                end
              end
            end
          end
          PH_LATCH: begin
            tick_cnt_nxt = tick_inc[15:0];
            if (tick_inc >= {1'b0, latch_thr}) begin
              tick_cnt_nxt = '0;
              phase_nxt    = PH_IDLE;
              done         = 1'b1;
            end
          end
          default: ;
        endcase
      end else if (phase_r == PH_IDLE) begin
        if (is_set) begin
          acc = (32'(in_led_index) < 32'(led_count));
        end else begin
          acc          = 1'b1;
          clear_start  = (in_cmd == rgbls_pkg::CMD_CLEAR);
          led_cnt_nxt  = '0;
          bit_cnt_nxt  = '0;
          tick_cnt_nxt = '0;
          if (led_count == '0) begin
            shift_nxt = '0;
            phase_nxt = PH_LATCH;
          end else begin
            // a clear zeroes everything, so entry 0 is known without a read
            shift_nxt = clear_start ? '0 : rd_word;
            phase_nxt = PH_HIGH;
          end
        end
      end
    end
  end

  // single write port: zeroing pass, else an accepted set
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_ptr_r;
    mem_wdata = '0;
    if (clr_active_r) begin
      mem_we = 1'b1;
    end else if (in_acc && is_set && acc) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(in_led_index);
      mem_wdata = {in_green, in_red, in_blue};
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_ptr_nxt    = clr_ptr_r;
    if (clear_start) begin
      clr_active_nxt = 1'b1;
      clr_ptr_nxt    = '0;
    end else if (clr_active_r) begin
      if (clr_ptr_r == AW'(MAX_LEDS - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_ptr_nxt = clr_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r    <= mem[rd_addr];
    fwd_data_r <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r     <= 1'b0;
      rd_zero_r <= 1'b1;
    end else begin
      fwd_r     <= mem_we && (mem_waddr == rd_addr);
      // entries at or above the pass pointer are not yet zeroed in the array
      rd_zero_r <= clr_active_r && (rd_addr >= clr_ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      shift_r      <= '0;
      led_cnt_r    <= '0;
      bit_cnt_r    <= '0;
      tick_cnt_r   <= '0;
      clr_active_r <= 1'b1;
      clr_ptr_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      led_cnt_r    <= led_cnt_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      clr_active_r <= clr_active_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pin_r  <= pin;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_acc_r  <= acc;
      out_done_r <= done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_level  = out_pin_r;
  assign out_busy_res   = out_busy_r;
  assign out_accepted   = out_acc_r;
  assign out_frame_done = out_done_r;

endmodule

// ===== rtl/core/rgbls_checker.sv =====
// Port-level checker for the LED strip serializer and its bind.
`include "assert_macros.svh"

module rgbls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_pin_level,
  input logic        out_busy_res,
  input logic        out_accepted,
  input logic        out_frame_done
);

  // a held result beat stays put
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pin_level) && $stable(out_busy_res) && $stable(out_frame_done))

  // a blocked output backs up into the input side
  `ASSERT_CLK(a_backpressure, out_valid && out_stall |-> in_stall)

  // the line only goes high on a tick while a refresh runs
  `ASSERT_CLK(a_pin_busy, out_valid && out_pin_level |-> out_busy_res && out_accepted && !out_frame_done)

  // the end of the latch period leaves the block idle
  `ASSERT_CLK(a_done_idle, out_valid && out_frame_done |-> !out_busy_res && out_accepted)

endmodule

bind rgb_led_strip_serializer rgbls_checker u_rgbls_checker (.*);

// ===== test/rgb_led_strip_serializer_test.sv =====
// Self-checking testbench for the LED strip serializer: directed table, extremes, random phases.
`timescale 1ns / 1ps

module rgb_led_strip_serializer_test;

  localparam int MAX_LEDS       = 64;
  localparam int PHASE_ITEMS    = 100;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  // indexes past the register list; writes there must be dropped
  localparam rgbls_pkg::reg_idx_t REG_SPARE_LO = 3'd6;
  localparam rgbls_pkg::reg_idx_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } strip_result_t;

  typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_t;

  typedef struct packed {
    rgbls_pkg::cmd_t cmd;
    logic [5:0]      idx;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            fixed;
    logic            run_out;
    strip_result_t   want;
  } stim_row_t;

  localparam strip_result_t RES_IDLE_ACK  = '{1'b0, 1'b0, 1'b1, 1'b0};
  localparam strip_result_t RES_IDLE_NAK  = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam strip_result_t RES_BUSY_ACK  = '{1'b0, 1'b1, 1'b1, 1'b0};
  localparam strip_result_t RES_BUSY_NAK  = '{1'b0, 1'b1, 1'b0, 1'b0};
  localparam strip_result_t RES_LINE_HIGH = '{1'b1, 1'b1, 1'b1, 1'b0};
  localparam strip_result_t RES_NONE      = '0;

  // active count is 2 here, so index 2 and up are out of range
  localparam stim_row_t DIRECTED [22] = '{
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_SET,   6'd0,  8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_SET,   6'd1,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_SET,   6'd2,  8'h12, 8'h34, 8'h56, 1'b1, 1'b0, RES_IDLE_NAK},
    '{rgbls_pkg::CMD_SET,   6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, RES_IDLE_NAK},
    '{rgbls_pkg::CMD_SET,   6'd1,  8'hFF, 8'h00, 8'hAA, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_SET,   6'd0,  8'h55, 8'h0F, 8'hF0, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_START, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_BUSY_ACK},
    '{rgbls_pkg::CMD_SET,   6'd1,  8'h11, 8'h22, 8'h33, 1'b1, 1'b0, RES_BUSY_NAK},
    '{rgbls_pkg::CMD_START, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_BUSY_NAK},
    '{rgbls_pkg::CMD_CLEAR, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_BUSY_NAK},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_LINE_HIGH},
    '{rgbls_pkg::CMD_TICK,  6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, RES_NONE},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, RES_NONE},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_SET,   6'd1,  8'hA5, 8'h5A, 8'hC3, 1'b1, 1'b0, RES_IDLE_ACK},
    '{rgbls_pkg::CMD_CLEAR, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_BUSY_ACK},
    '{rgbls_pkg::CMD_SET,   6'd1,  8'h01, 8'h02, 8'h03, 1'b1, 1'b0, RES_BUSY_NAK},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, RES_NONE},
    '{rgbls_pkg::CMD_START, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_BUSY_ACK},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, RES_NONE},
    '{rgbls_pkg::CMD_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, RES_IDLE_ACK}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [5:0]  in_led_index;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic        out_pin_level;
  logic        out_busy_res;
  logic        out_accepted;
  logic        out_frame_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  rgb_led_strip_serializer #(.MAX_LEDS(MAX_LEDS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_led_index   (in_led_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_level  (out_pin_level),
    .out_busy_res   (out_busy_res),
    .out_accepted   (out_accepted),
    .out_frame_done (out_frame_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // predictor state
  rgbls_pkg::ticks_t cfg_zero_high, cfg_zero_low, cfg_one_high, cfg_one_low, cfg_latch;
  logic [6:0]        cfg_active;
  rgbls_pkg::color_t strip_mem [MAX_LEDS];
  rgbls_pkg::color_t shift_q;
  logic [6:0]        led_pos;
  logic [4:0]        bit_pos;
  line_phase_t       line_phase;
  int unsigned       tick_cnt;

  strip_result_t line_beats_due [$];
  string         field_name [4] = '{"frame_done", "accepted", "busy_res", "pin_level"};

  logic          row_fixed;
  strip_result_t row_want;
  logic          refresh_busy = 1'b0;
  bit            hold_req = 1'b0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            items_sent = 0;
  int            err_cnt = 0;
  int            quiet_cycles = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned min_one(rgbls_pkg::ticks_t v);
    return (v == '0) ? 1 : 32'(v);
  endfunction

  function automatic int unsigned led_total();
    return (cfg_active > MAX_LEDS) ? MAX_LEDS : 32'(cfg_active);
  endfunction

  function automatic strip_result_t step_strip(rgbls_pkg::cmd_t cmd, logic [5:0] idx,
                                               logic [7:0] red, logic [7:0] green,
                                               logic [7:0] blue);
    strip_result_t res;
    logic          cur_bit;
    res = '0;
    cur_bit = shift_q[23];
    if (cmd == rgbls_pkg::CMD_TICK) begin
      res.accepted = 1'b1;
      case (line_phase)
        LINE_HIGH: begin
          res.pin_level = 1'b1;
          tick_cnt++;
          if (tick_cnt >= min_one(cur_bit ? cfg_one_high : cfg_zero_high)) begin
            tick_cnt = 0;
            line_phase = LINE_LOW;
          end
        end
        LINE_LOW: begin
          tick_cnt++;
          if (tick_cnt >= min_one(cur_bit ? cfg_one_low : cfg_zero_low)) begin
            tick_cnt = 0;
            shift_q = shift_q << 1;
            bit_pos++;
            line_phase = LINE_HIGH;
            if (bit_pos >= rgbls_pkg::BITS_PER_LED) begin
              bit_pos = '0;
              led_pos++;
              if (led_pos >= led_total()) begin
                shift_q = '0;
                line_phase = LINE_LATCH;
              end else begin
                shift_q = strip_mem[led_pos[5:0]];
              end
            end
          end
        end
        LINE_LATCH: begin
          tick_cnt++;
          if (tick_cnt >= min_one(cfg_latch)) begin
            tick_cnt = 0;
            line_phase = LINE_IDLE;
            res.frame_done = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (line_phase == LINE_IDLE) begin
      if (cmd == rgbls_pkg::CMD_SET) begin
        if (idx < led_total()) begin
          strip_mem[idx] = {green, red, blue};
          res.accepted = 1'b1;
        end
      end else begin
        // clear wipes the whole store, not just the active part
        if (cmd == rgbls_pkg::CMD_CLEAR) begin
          foreach (strip_mem[k]) strip_mem[k] = '0;
        end
        led_pos = '0;
        bit_pos = '0;
        tick_cnt = 0;
        if (led_total() == 0) begin
          shift_q = '0;
          line_phase = LINE_LATCH;
        end else begin
          shift_q = strip_mem[0];
          line_phase = LINE_HIGH;
        end
        res.accepted = 1'b1;
      end
    end
    res.busy_res = (line_phase != LINE_IDLE);
    return res;
  endfunction

  task automatic send_item(input rgbls_pkg::cmd_t c, input logic [5:0] idx,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic fixed = 1'b0,
                           input strip_result_t want = '0);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_led_index <= idx;
    in_red       <= red;
    in_green     <= green;
    in_blue      <= blue;
    row_fixed    <= fixed;
    row_want     <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // a noise beat may itself start a refresh, so one more look is taken after it
  task automatic tick_until_idle(input int noise_pct);
    bit noisy;
    do begin
      noisy = (noise_pct != 0) && ($urandom_range(99) < noise_pct);
      if (noisy)
        send_item(rgbls_pkg::cmd_t'($urandom_range(rgbls_pkg::CMD_SET, rgbls_pkg::CMD_CLEAR)),
                  6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_item(rgbls_pkg::CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    end while (refresh_busy || noisy);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_cfg(input rgbls_pkg::ticks_t zero_high, input rgbls_pkg::ticks_t zero_low,
                          input rgbls_pkg::ticks_t one_high, input rgbls_pkg::ticks_t one_low,
                          input rgbls_pkg::ticks_t latch, input logic [6:0] active);
    rgbls_pkg::ticks_t   vals [7];
    rgbls_pkg::reg_idx_t regs [7];
    rgbls_pkg::ticks_t   active_word;
    active_word = rgbls_pkg::ticks_t'($urandom);
    active_word[6:0] = active;
    vals = '{zero_high, zero_low, one_high, one_low, latch, active_word,
             rgbls_pkg::ticks_t'($urandom)};
    regs = '{rgbls_pkg::REG_ZERO_HIGH, rgbls_pkg::REG_ZERO_LOW, rgbls_pkg::REG_ONE_HIGH,
             rgbls_pkg::REG_ONE_LOW, rgbls_pkg::REG_LATCH, rgbls_pkg::REG_ACTIVE,
             ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO};
    for (int k = 0; k < 7; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input bit squeeze);
    int goal;
    int n;
    goal = items_sent + PHASE_ITEMS;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    load_cfg(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
             16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
             16'($urandom_range(0, 5)), 7'($urandom_range(0, 3)));
    if (squeeze) hold_req <= 1'b1;
    while (items_sent < goal) begin
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(3) == 0)
          send_item(rgbls_pkg::CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        else
          send_item(rgbls_pkg::CMD_SET, 6'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      end
      // now and then the frame is loaded but never sent
      if ($urandom_range(9) != 0) begin
        send_item(($urandom_range(4) == 0) ? rgbls_pkg::CMD_CLEAR : rgbls_pkg::CMD_START,
                  6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        tick_until_idle(10);
      end
    end
    settle();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : track
    strip_result_t res;
    strip_result_t got;
    strip_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rgbls_pkg::REG_ZERO_HIGH: cfg_zero_high = cfg_data;
          rgbls_pkg::REG_ZERO_LOW:  cfg_zero_low  = cfg_data;
          rgbls_pkg::REG_ONE_HIGH:  cfg_one_high  = cfg_data;
          rgbls_pkg::REG_ONE_LOW:   cfg_one_low   = cfg_data;
          rgbls_pkg::REG_LATCH:     cfg_latch     = cfg_data;
          rgbls_pkg::REG_ACTIVE:    cfg_active    = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        res = step_strip(in_cmd, in_led_index, in_red, in_green, in_blue);
        line_beats_due.push_back(row_fixed ? row_want : res);
        refresh_busy <= res.busy_res;
      end
      if (out_valid && !out_stall) begin
        got = {out_pin_level, out_busy_res, out_accepted, out_frame_done};
        if (line_beats_due.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          want = line_beats_due.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got[f] !== want[f]) begin
              $error("%s: expected %0b, got %0b", field_name[f], want[f], got[f]);
              err_cnt++;
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = rgbls_pkg::CMD_TICK;
    in_led_index = '0;
    in_red       = '0;
    in_green     = '0;
    in_blue      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = rgbls_pkg::REG_ZERO_HIGH;
    cfg_data     = '0;
    row_fixed    = 1'b0;
    row_want     = '0;

    cfg_zero_high = rgbls_pkg::RST_ZERO_HIGH;
    cfg_zero_low  = rgbls_pkg::RST_ZERO_LOW;
    cfg_one_high  = rgbls_pkg::RST_ONE_HIGH;
    cfg_one_low   = rgbls_pkg::RST_ONE_LOW;
    cfg_latch     = rgbls_pkg::RST_LATCH;
    cfg_active    = rgbls_pkg::RST_ACTIVE;
    foreach (strip_mem[k]) strip_mem[k] = '0;
    shift_q    = '0;
    led_pos    = '0;
    bit_pos    = '0;
    line_phase = LINE_IDLE;
    tick_cnt   = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // short bit times and a two-LED strip keep the frames of the table cheap
    load_cfg(16'd1, 16'd1, 16'd1, 16'd1, 16'd3, 7'd2);
    foreach (DIRECTED[r]) begin
      send_item(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].red, DIRECTED[r].green,
                DIRECTED[r].blue, DIRECTED[r].fixed, DIRECTED[r].want);
      if (DIRECTED[r].run_out) tick_until_idle(0);
    end
    settle();

    // count above the store size is capped, so the top index is writable
    load_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd127);
    send_item(rgbls_pkg::CMD_SET, 6'd63, 8'($urandom), 8'($urandom), 8'($urandom));
    send_item(rgbls_pkg::CMD_SET, 6'd1, 8'hFF, 8'hFF, 8'hFF);
    settle();
    // a clear with a short strip must still wipe the entries past it
    load_cfg(16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 7'd1);
    send_item(rgbls_pkg::CMD_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00);
    tick_until_idle(0);
    settle();
    // zero bit times act as one tick
    load_cfg(16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 7'd2);
    send_item(rgbls_pkg::CMD_START, 6'd0, 8'h00, 8'h00, 8'h00);
    tick_until_idle(0);
    settle();

    // empty strip: refresh goes straight to the latch
    load_cfg(16'd1, 16'd1, 16'd1, 16'd1, 16'd20, 7'd0);
    send_item(rgbls_pkg::CMD_SET, 6'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(rgbls_pkg::CMD_START, 6'd0, 8'h00, 8'h00, 8'h00);
    send_item(rgbls_pkg::CMD_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00);
    tick_until_idle(0);
    settle();

    // long one bit, then long zero bit, one long bit in each of the two frames
    load_cfg(16'd1, 16'd1, 16'd16, 16'd16, 16'd1, 7'd1);
    send_item(rgbls_pkg::CMD_SET, 6'd0, 8'h00, 8'h00, 8'h01);
    send_item(rgbls_pkg::CMD_START, 6'd0, 8'h00, 8'h00, 8'h00);
    tick_until_idle(0);
    settle();
    load_cfg(16'd16, 16'd16, 16'd1, 16'd1, 16'd1, 7'd1);
    send_item(rgbls_pkg::CMD_SET, 6'd0, 8'hFF, 8'hFF, 8'hFE);
    send_item(rgbls_pkg::CMD_START, 6'd0, 8'h00, 8'h00, 8'h00);
    tick_until_idle(0);
    settle();

    random_phase(0, 0, 1'b1);
    random_phase(75, 0, 1'b0);
    random_phase(0, 75, 1'b0);
    random_phase(9, 9, 1'b0);

    repeat (8) @(posedge clk);
    if (line_beats_due.size() != 0) begin
      $error("%0d result beats never arrived", line_beats_due.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
